// File: design/tsjf_pkg.sv
// ----------------------------------------------------------------------------
// tsjf_pkg
// Shared types and constants of the touch slot jitter filter.
// ----------------------------------------------------------------------------
package tsjf_pkg;

	localparam int NUM_SLOTS_DEF   = 10;
	localparam int MAX_POINTS_DEF  = 5;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ID_W    = 4;
	localparam int PX_W    = 12;
	localparam int COORD_W = 16;
	localparam int TH_W    = 8;
	localparam int TC_W    = 8;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL   = 3'd4;

	localparam logic [COORD_W-1:0] LIMIT_X_RST = 16'd1024;
	localparam logic [COORD_W-1:0] LIMIT_Y_RST = 16'd600;
	localparam logic [COORD_W-1:0] FLIP_RST    = 16'd600;
	localparam logic [TH_W-1:0]    BIG_RST     = 8'd3;
	localparam logic [TH_W-1:0]    SMALL_RST   = 8'd1;

	// Input action codes.
	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_FRAME = 1'b1;

	typedef enum logic [1:0] {
		EV_REPORT  = 2'd0,
		EV_RELEASE = 2'd1,
		EV_SYNC    = 2'd2
	} ev_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CALC,
		BK_COMMIT,
		BK_WALK,
		BK_SYNC
	} bk_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] limit_x;
		logic [COORD_W-1:0] limit_y;
		logic [COORD_W-1:0] flip;
		logic [TH_W-1:0]    mv_big;
		logic [TH_W-1:0]    mv_small;
	} cfg_t;

	// Command handed from the front end to the back end.
	typedef struct packed {
		logic               is_frame;
		logic [ID_W-1:0]    id;
		logic [PX_W-1:0]    px;
		logic [COORD_W-1:0] py;
		logic               zero_count;
	} cmd_t;

endpackage

// File: design/tsjf_front.sv
// ----------------------------------------------------------------------------
// tsjf_front
// Accepts input beats, enforces the per-frame point limit, drops points with
// an invalid id and queues the remaining work for the back end.
// ----------------------------------------------------------------------------
module tsjf_front import tsjf_pkg::*; #(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_action,
	input  logic [ID_W-1:0]    in_id,
	input  logic [PX_W-1:0]    in_px,
	input  logic [COORD_W-1:0] in_py,
	input  logic [TC_W-1:0]    in_touches,
	output logic               push,
	output cmd_t               push_cmd,
	input  logic               q_full
);

	localparam int PW = $clog2(MAX_POINTS + 1);

	logic [PW-1:0] points_q;
	logic          accept;
	logic          room;
	logic          id_ok;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign room     = points_q < PW'(MAX_POINTS);
	assign id_ok    = (in_id != '0) && (in_id <= ID_W'(NUM_SLOTS));

	always_comb begin
		push_cmd.is_frame   = (in_action == ACT_FRAME);
		push_cmd.id         = in_id;
		push_cmd.px         = in_px;
		push_cmd.py         = in_py;
		push_cmd.zero_count = (in_touches == '0);
		if (in_action == ACT_FRAME) begin
			push = accept;
		end else begin
			push = accept && room && id_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (accept) begin
			if (in_action == ACT_FRAME) begin
				points_q <= '0;
			end else if (room) begin
				points_q <= points_q + PW'(1);
			end
		end
	end

endmodule

// File: design/tsjf_queue.sv
// ----------------------------------------------------------------------------
// tsjf_queue
// Short first-word-fall-through queue of commands between front and back.
// ----------------------------------------------------------------------------
module tsjf_queue import tsjf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(DEPTH);

	cmd_t        mem [DEPTH];
	logic [AW:0] wr_q;
	logic [AW:0] rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
	assign head  = mem[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_q[AW-1:0]] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + (AW+1)'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + (AW+1)'(1);
			end
		end
	end

endmodule

// File: design/tsjf_back.sv
// ----------------------------------------------------------------------------
// tsjf_back
// Carries out queued commands: point smoothing against the slot state and the
// frame-end walk over all slots, feeding a registered output stage.
// ----------------------------------------------------------------------------
module tsjf_back import tsjf_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               head,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output ev_kind_t           out_kind,
	output logic [ID_W-1:0]    out_slot,
	output logic [COORD_W-1:0] out_x,
	output logic [COORD_W-1:0] out_y,
	output logic               out_last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	bk_state_t state_q;
	bk_state_t state_nxt;

	cmd_t               cmd_q;
	logic [IDX_W-1:0]   walk_q;
	logic [IDX_W-1:0]   idx;

	logic [COORD_W-1:0] kept_x_q [NUM_SLOTS];
	logic [COORD_W-1:0] kept_y_q [NUM_SLOTS];
	logic [1:0]         hit_q    [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] seen_now_q;
	logic [NUM_SLOTS-1:0] seen_before_q;

	// Point stage registers.
	logic [COORD_W-1:0] kx_s1, ky_s1, ax_s1, ay_s1, dx_s1, dy_s1;
	logic [1:0]         hit_s1;

	// Calculation stage logic.
	logic [1:0]         hit_old;
	logic               first;
	logic [COORD_W-1:0] kx, ky, ax, ay;
	logic [COORD_W:0]   sum_x, sum_y;

	// Commit stage logic.
	logic [COORD_W-1:0] big_w, small_w, nx, ny, rx, ry;
	logic               both, on_screen;

	// Control.
	logic               out_free;
	logic               load_out;
	ev_kind_t           ld_kind;
	logic [ID_W-1:0]    ld_slot;
	logic [COORD_W-1:0] ld_x, ld_y;
	logic               ld_last;
	logic               commit_pt;
	logic               walk_step;
	logic               walk_rel;
	logic               out_valid_q;

	assign idx      = IDX_W'(cmd_q.id - ID_W'(1));
	assign out_free = !out_valid_q || out_ready;
	assign walk_rel = cmd_q.zero_count || (seen_before_q[walk_q] && !seen_now_q[walk_q]);

	always_comb begin
		hit_old = hit_q[idx];
		first   = (hit_old == 2'd0);
		kx      = first ? COORD_W'(cmd_q.px) : kept_x_q[idx];
		ky      = first ? cmd_q.py : kept_y_q[idx];
		sum_x   = {1'b0, kx} + (COORD_W+1)'(cmd_q.px);
		sum_y   = {1'b0, ky} + {1'b0, cmd_q.py};
		ax      = sum_x[COORD_W:1];
		ay      = sum_y[COORD_W:1];
	end

	always_comb begin
		big_w     = COORD_W'(cfg.mv_big);
		small_w   = COORD_W'(cfg.mv_small);
		both      = (dx_s1 > big_w && dy_s1 > small_w) || (dx_s1 > small_w && dy_s1 > big_w);
		nx        = (both || dx_s1 > big_w) ? ax_s1 : kx_s1;
		ny        = (both || dy_s1 > big_w) ? ay_s1 : ky_s1;
		rx        = ny;
		ry        = cfg.flip - nx;
		on_screen = (rx <= cfg.limit_x) && (ry <= cfg.limit_y);
	end

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load_out  = 1'b0;
		ld_kind   = EV_REPORT;
		ld_slot   = cmd_q.id;
		ld_x      = rx;
		ld_y      = ry;
		ld_last   = 1'b1;
		commit_pt = 1'b0;
		walk_step = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop       = 1'b1;
					state_nxt = head.is_frame ? BK_WALK : BK_CALC;
				end
			end
			BK_CALC: begin
				state_nxt = BK_COMMIT;
			end
			BK_COMMIT: begin
				if (out_free) begin
					commit_pt = 1'b1;
					load_out  = on_screen;
					state_nxt = BK_IDLE;
				end
			end
			BK_WALK: begin
				ld_kind = EV_RELEASE;
				ld_slot = ID_W'(walk_q) + ID_W'(1);
				ld_x    = '0;
				ld_y    = '0;
				ld_last = 1'b0;
				if (!walk_rel || out_free) begin
					walk_step = 1'b1;
					load_out  = walk_rel;
					if (walk_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_nxt = BK_SYNC;
					end
				end
			end
			BK_SYNC: begin
				ld_kind = EV_SYNC;
				ld_slot = '0;
				ld_x    = '0;
				ld_y    = '0;
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Command latch, walk counter and point stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (pop) begin
			walk_q <= '0;
		end else if (walk_step) begin
			walk_q <= walk_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == BK_CALC) begin
			kx_s1  <= kx;
			ky_s1  <= ky;
			ax_s1  <= ax;
			ay_s1  <= ay;
			dx_s1  <= (ax > kx) ? ax - kx : kx - ax;
			dy_s1  <= (ay > ky) ? ay - ky : ky - ay;
			hit_s1 <= (hit_old == 2'd2) ? 2'd2 : hit_old + 2'd1;
		end
	end

	// Kept positions are only read once a slot has been hit, so no reset.
	always_ff @(posedge clk) begin
		if (commit_pt) begin
			kept_x_q[idx] <= nx;
			kept_y_q[idx] <= ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				hit_q[i] <= '0;
			end
			seen_now_q    <= '0;
			seen_before_q <= '0;
		end else begin
			if (commit_pt) begin
				hit_q[idx]      <= hit_s1;
				seen_now_q[idx] <= 1'b1;
			end
			if (walk_step) begin
				if (walk_rel) begin
					hit_q[walk_q] <= '0;
				end
				seen_before_q[walk_q] <= seen_now_q[walk_q];
				seen_now_q[walk_q]    <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind <= ld_kind;
			out_slot <= ld_slot;
			out_x    <= ld_x;
			out_y    <= ld_y;
			out_last <= ld_last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_WALK |-> walk_q <= IDX_W'(NUM_SLOTS - 1))
		else $error("frame walk ran past the last slot");
	a_report_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind == EV_REPORT |->
			out_slot != '0 && out_slot <= ID_W'(NUM_SLOTS) && out_last)
		else $error("position report with a bad slot or without last");
	a_sync_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind == EV_SYNC |-> out_last && out_slot == '0)
		else $error("frame sync malformed");
	a_release_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind == EV_RELEASE |-> !out_last && out_x == '0 && out_y == '0)
		else $error("slot release malformed");
	a_no_load_stall: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("output register overwritten while stalled");
`endif

endmodule

// File: design/touch_slot_jitter_filter.sv
// ----------------------------------------------------------------------------
// touch_slot_jitter_filter
// Per-contact touch tracker with jitter smoothing, axis swap and flip.
// ----------------------------------------------------------------------------
// Usage: input beats arrive on the s_ stream. tuser carries the action (touch
// point or end of frame), tdata the contact id, raw coordinates and the touch
// count. Result beats leave on the m_ stream with the event kind in tuser and
// tlast set on the final result that an input beat causes.
// Configuration registers are written over the cfg_ channel, which is always
// ready; write them only while the block is idle.
// A front end counts points per frame, drops points beyond the frame limit or
// with an invalid id, and queues the rest. A back end executes one queued
// command at a time. A touch point's command is popped, calculated into the
// point stage and committed, which loads its report into the output register
// if on screen; no new command is taken until the last one has finished. A
// frame end pops, walks the slots one per cycle while no release waits on a
// stalled receiver, and then loads the sync. Input is taken while the queue
// has room, even while a result waits.
// Reset clears the slot hit and seen state, the point counter, the queue and
// the output valid; configuration returns to its default values. When the
// receiver stalls, the output register holds its beat, the back end waits
// and the queue fills, after which s_tready drops.
// ----------------------------------------------------------------------------
module touch_slot_jitter_filter import tsjf_pkg::*; #(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// contact_id[3:0], point_x[15:4], point_y[31:16], touch_count[39:32]
	input  logic [39:0]          s_tdata,
	// action[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// slot[3:0], out_x[19:4], out_y[35:20], zero fill [39:36]
	output logic [39:0]          m_tdata,
	// event_kind[1:0]
	output logic [1:0]           m_tuser,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	cfg_t               cfg_q;
	logic               push;
	cmd_t               push_cmd;
	cmd_t               head;
	logic               q_empty;
	logic               q_full;
	logic               pop;
	ev_kind_t           out_kind;
	logic [ID_W-1:0]    out_slot;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;

	// Register file. Writes to indexes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_x  <= LIMIT_X_RST;
			cfg_q.limit_y  <= LIMIT_Y_RST;
			cfg_q.flip     <= FLIP_RST;
			cfg_q.mv_big   <= BIG_RST;
			cfg_q.mv_small <= SMALL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIMIT_X: cfg_q.limit_x  <= cfg_data;
				REG_LIMIT_Y: cfg_q.limit_y  <= cfg_data;
				REG_FLIP:    cfg_q.flip     <= cfg_data;
				REG_BIG:     cfg_q.mv_big   <= cfg_data[TH_W-1:0];
				REG_SMALL:   cfg_q.mv_small <= cfg_data[TH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tsjf_front #(
		.NUM_SLOTS  (NUM_SLOTS),
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_id      (s_tdata[3:0]),
		.in_px      (s_tdata[15:4]),
		.in_py      (s_tdata[31:16]),
		.in_touches (s_tdata[39:32]),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	tsjf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	tsjf_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_slot  (out_slot),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {4'd0, out_y, out_x, out_slot};

endmodule

// File: dv/touch_slot_jitter_filter_checker.sv
// ----------------------------------------------------------------------------
// touch_slot_jitter_filter_checker
// Watches the input, result and register channels of the touch slot jitter
// filter, tracks every contact slot on its own and compares each result beat
// with the oldest predicted event.
// ----------------------------------------------------------------------------
module touch_slot_jitter_filter_checker import tsjf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [39:0]          s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [39:0]          m_tdata,
	input  logic [1:0]           m_tuser,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	output int                   mismatches,
	output int                   awaiting,
	output int                   beats_in,
	output int                   reports,
	output int                   releases,
	output int                   syncs
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
	localparam int MAX_POINTS = MAX_POINTS_DEF;

	typedef struct packed {
		ev_kind_t           kind;
		logic [ID_W-1:0]    slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} touch_event_t;

	touch_event_t events_due[$];

	logic [COORD_W-1:0] lim_x, lim_y, flip;
	logic [TH_W-1:0]    thr_big, thr_small;
	logic [COORD_W-1:0] kept_x [1:NUM_SLOTS];
	logic [COORD_W-1:0] kept_y [1:NUM_SLOTS];
	logic [1:0]         hits [1:NUM_SLOTS];
	logic               seen_now [1:NUM_SLOTS];
	logic               seen_prev [1:NUM_SLOTS];
	int                 frame_points;
	int                 err_count, n_in, n_rep, n_rel, n_sync;

	task automatic clear_tracker();
		for (int s = 1; s <= NUM_SLOTS; s++) begin
			kept_x[s]    = '0;
			kept_y[s]    = '0;
			hits[s]      = '0;
			seen_now[s]  = 1'b0;
			seen_prev[s] = 1'b0;
		end
		frame_points = 0;
		lim_x        = LIMIT_X_RST;
		lim_y        = LIMIT_Y_RST;
		flip         = FLIP_RST;
		thr_big      = BIG_RST;
		thr_small    = SMALL_RST;
		events_due.delete();
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [COORD_W-1:0] val);
		case (idx)
			REG_LIMIT_X: lim_x     = val;
			REG_LIMIT_Y: lim_y     = val;
			REG_FLIP:    flip      = val;
			REG_BIG:     thr_big   = val[TH_W-1:0];
			REG_SMALL:   thr_small = val[TH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_event(input ev_kind_t kind, input logic [ID_W-1:0] slot,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y, input logic last);
		touch_event_t ev;
		ev.kind = kind;
		ev.slot = slot;
		ev.x    = x;
		ev.y    = y;
		ev.last = last;
		events_due.push_back(ev);
	endtask

	task automatic track_point(input logic [ID_W-1:0] id, input logic [PX_W-1:0] px,
			input logic [COORD_W-1:0] py);
		int                 ax, ay, dx, dy;
		logic               both;
		logic [COORD_W-1:0] rx, ry;
		if (frame_points >= MAX_POINTS)
			return;
		frame_points++;
		// Bad ids still use up one of the frame's point places.
		if (id < 1 || id > NUM_SLOTS)
			return;
		if (hits[id] < 2)
			hits[id]++;
		if (hits[id] == 1) begin
			kept_x[id] = COORD_W'(px);
			kept_y[id] = py;
		end
		ax = (int'(kept_x[id]) + int'(px)) >> 1;
		ay = (int'(kept_y[id]) + int'(py)) >> 1;
		dx = (ax > int'(kept_x[id])) ? ax - int'(kept_x[id]) : int'(kept_x[id]) - ax;
		dy = (ay > int'(kept_y[id])) ? ay - int'(kept_y[id]) : int'(kept_y[id]) - ay;
		both = (dx > int'(thr_big) && dy > int'(thr_small)) ||
			(dx > int'(thr_small) && dy > int'(thr_big));
		if (both || dx > int'(thr_big))
			kept_x[id] = COORD_W'(ax);
		if (both || dy > int'(thr_big))
			kept_y[id] = COORD_W'(ay);
		seen_now[id] = 1'b1;
		rx = kept_y[id];
		ry = flip - kept_x[id];
		if (rx > lim_x || ry > lim_y)
			return;
		queue_event(EV_REPORT, id, rx, ry, 1'b1);
	endtask

	task automatic close_frame(input logic [TC_W-1:0] touches);
		for (int s = 1; s <= NUM_SLOTS; s++) begin
			if (touches == 0 || (seen_prev[s] && !seen_now[s])) begin
				queue_event(EV_RELEASE, ID_W'(s), '0, '0, 1'b0);
				hits[s] = '0;
			end
			seen_prev[s] = seen_now[s];
			seen_now[s]  = 1'b0;
		end
		queue_event(EV_SYNC, '0, '0, '0, 1'b1);
		frame_points = 0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic compare_event();
		touch_event_t want;
		if (events_due.size() == 0) begin
			$error("result beat with nothing expected: kind %0d slot %0d",
				m_tuser, m_tdata[3:0]);
			err_count++;
			return;
		end
		want = events_due.pop_front();
		check_field("event_kind", 32'(want.kind), 32'(m_tuser));
		check_field("slot", 32'(want.slot), 32'(m_tdata[3:0]));
		check_field("out_x", 32'(want.x), 32'(m_tdata[19:4]));
		check_field("out_y", 32'(want.y), 32'(m_tdata[35:20]));
		check_field("last", 32'(want.last), 32'(m_tlast));
		check_field("zero fill", 32'd0, 32'(m_tdata[39:36]));
		case (want.kind)
			EV_REPORT:  n_rep++;
			EV_RELEASE: n_rel++;
			default:    n_sync++;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tracker();
			err_count = 0;
			n_in      = 0;
			n_rep     = 0;
			n_rel     = 0;
			n_sync    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (m_tvalid && m_tready)
				compare_event();
			if (s_tvalid && s_tready) begin
				n_in++;
				if (s_tuser == ACT_POINT)
					track_point(s_tdata[3:0], s_tdata[15:4], s_tdata[31:16]);
				else
					close_frame(s_tdata[39:32]);
			end
		end
		mismatches <= err_count;
		awaiting   <= events_due.size();
		beats_in   <= n_in;
		reports    <= n_rep;
		releases   <= n_rel;
		syncs      <= n_sync;
	end

endmodule

// File: dv/touch_slot_jitter_filter_test.sv
// ----------------------------------------------------------------------------
// touch_slot_jitter_filter_test
// Stimulus and verdict for the touch slot jitter filter.
// A directed opening walks the special cases of slot tracking under the reset
// settings; random frames of tracked, jittering contacts then run under
// several register settings, extremes included, while a checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module touch_slot_jitter_filter_test;
	import tsjf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any handshake after which the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Idle cycles let pass before a register write and at the end. A frame
	// end walks every slot, and dropped points leave no result behind, so this
	// covers the tail of the block's work.
	localparam int SETTLE_CYCLES  = 32;
	localparam int NUM_PHASES     = 6;

	// Receiver stall patterns.
	localparam logic [1:0] RX_FREE   = 2'd0;
	localparam logic [1:0] RX_COIN   = 2'd1;
	localparam logic [1:0] RX_COMB   = 2'd2;
	localparam logic [1:0] RX_SPARSE = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic [39:0]          s_tdata   = '0;
	logic                 s_tuser   = ACT_POINT;
	logic                 m_tready  = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;
	logic                 s_tready, m_tvalid, m_tlast, cfg_ready;
	logic [39:0]          m_tdata;
	logic [1:0]           m_tuser;

	int mismatches, awaiting, beats_in, reports, releases, syncs;

	touch_slot_jitter_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	touch_slot_jitter_filter_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting),
		.beats_in   (beats_in),
		.reports    (reports),
		.releases   (releases),
		.syncs      (syncs)
	);

	always #6 clk = ~clk;

	// The receiver switches at random between stall patterns:
	// always ready, a coin toss, a fixed comb, and rare acceptance that lets
	// the output register and the command queue fill up.
	logic [1:0] rx_mode  = RX_FREE;
	int         rx_timer = 0;
	int         rx_cycle = 0;

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_timer == 0) begin
			rx_mode  <= 2'($urandom_range(0, 3));
			rx_timer <= $urandom_range(20, 120);
		end else begin
			rx_timer <= rx_timer - 1;
		end
		case (rx_mode)
			RX_FREE:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_COMB:   m_tready <= (rx_cycle % 5) != 0;
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= 1'b1;
		endcase
	end

	// Watchdog: any accepted beat on any channel restarts the count.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** touch_slot_jitter_filter: FAILED **");
			$finish;
		end
	end

	// Stimulus state. The current settings are mirrored here only so that
	// generated points land mostly inside the reported window.
	int burst_left = 0;
	int items_sent = 0;
	int settings_run = 1;
	int hot_slots = 3;
	int px_lo, px_hi, py_hi, jitter;
	int cur_lim_x, cur_lim_y, cur_flip, cur_big;
	int base_x [1:NUM_SLOTS_DEF];
	int base_y [1:NUM_SLOTS_DEF];

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// A point is reported when its kept y is at most limit_x and flip minus
	// its kept x is at most limit_y; this picks raw ranges that satisfy both.
	task automatic derive_window();
		px_lo = cur_flip - cur_lim_y;
		if (px_lo < 0)
			px_lo = 0;
		px_hi = (cur_flip > 4095) ? 4095 : cur_flip;
		if (px_lo > px_hi) begin
			px_lo = 0;
			px_hi = 4095;
		end
		py_hi  = cur_lim_x;
		jitter = (cur_big + 4 > 260) ? 260 : cur_big + 4;
		for (int s = 1; s <= NUM_SLOTS_DEF; s++) begin
			base_x[s] = $urandom_range(px_lo, px_hi);
			base_y[s] = $urandom_range(0, py_hi);
		end
	endtask

	// The sender moves in bursts with gaps of tvalid low between them; inside
	// a burst tvalid stays high from one beat to the next.
	task automatic send_item(input logic act, input int id, input int px, input int py,
			input int tc);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {8'(tc), 16'(py), 12'(px), 4'(id)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_point(input int id, input int px, input int py);
		send_item(ACT_POINT, id, px, py, $urandom_range(0, 255));
	endtask

	task automatic end_frame(input int tc);
		send_item(ACT_FRAME, $urandom_range(0, 15), $urandom_range(0, 4095),
			$urandom_range(0, 65535), tc);
	endtask

	// Waits until every predicted event has arrived and the block has had
	// time to finish any work that leaves no result.
	task automatic drain();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers back to back, then one index past the list,
	// which the block has to ignore.
	task automatic apply_settings(input int lx, input int ly, input int fl, input int bg,
			input int sm);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [COORD_W-1:0]   val [6];
		idx = '{REG_LIMIT_X, REG_LIMIT_Y, REG_FLIP, REG_BIG, REG_SMALL,
			REG_SMALL + CFG_IDX_W'(1 + $urandom_range(0, 2))};
		val = '{16'(lx), 16'(ly), 16'(fl), 16'(bg), 16'(sm), 16'($urandom)};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_lim_x = lx;
		cur_lim_y = ly;
		cur_flip  = fl;
		cur_big   = bg;
		settings_run++;
		derive_window();
	endtask

	// One random point: mostly a tracked contact jittering around its last
	// position, sometimes a jump, sometimes noise or an invalid id.
	task automatic emit_point();
		int id, px, py, roll, j;
		roll = $urandom_range(0, 99);
		if (roll < 7) begin
			id = $urandom_range(0, 5);
			if (id != 0)
				id = id + NUM_SLOTS_DEF;
		end else begin
			id = $urandom_range(1, hot_slots);
		end
		if (roll >= 7 && roll < 15) begin
			px = $urandom_range(0, 4095);
			py = $urandom_range(0, 65535);
		end else if (id < 1 || id > NUM_SLOTS_DEF || $urandom_range(0, 5) == 0) begin
			px = $urandom_range(px_lo, px_hi);
			py = $urandom_range(0, py_hi);
		end else begin
			j  = $urandom_range(0, 2 * jitter);
			px = clamp(base_x[id] + j - jitter, px_lo, px_hi);
			j  = $urandom_range(0, 2 * jitter);
			py = clamp(base_y[id] + j - jitter, 0, py_hi);
		end
		if (id >= 1 && id <= NUM_SLOTS_DEF) begin
			base_x[id] = px;
			base_y[id] = py;
		end
		send_point(id, px, py);
	endtask

	// One random frame. The set of active slots shrinks and grows between
	// frames so that slots go idle and get released; some frames overrun the
	// point limit and some end with a zero touch count.
	task automatic play_frame();
		int n, tc, roll;
		if ($urandom_range(0, 2) == 0)
			hot_slots = $urandom_range(1, NUM_SLOTS_DEF);
		roll = $urandom_range(0, 99);
		n = (roll < 10) ? $urandom_range(MAX_POINTS_DEF + 1, MAX_POINTS_DEF + 3)
			: $urandom_range(0, MAX_POINTS_DEF);
		repeat (n) emit_point();
		roll = $urandom_range(0, 99);
		if (roll < 12)
			tc = 0;
		else if (roll < 20)
			tc = $urandom_range(0, 255);
		else
			tc = (n > 0) ? n : 1;
		end_frame(tc);
	endtask

	initial begin
		int goal, quota;
		cur_lim_x = LIMIT_X_RST;
		cur_lim_y = LIMIT_Y_RST;
		cur_flip  = FLIP_RST;
		cur_big   = BIG_RST;
		derive_window();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset settings: limits 1024 and 600,
		// flip base 600, thresholds 3 and 1.
		// First touch of slot 1, a sub-threshold jitter, then a clear move.
		send_point(1, 100, 200);
		send_point(1, 101, 201);
		send_point(1, 120, 209);
		// Invalid ids at the field extremes still use up the frame's places,
		// so the sixth point is past the limit and ignored.
		send_point(0, 4095, 65535);
		send_point(15, 0, 0);
		send_point(2, 50, 50);
		end_frame(255);
		// Diagonal move: x beyond the big threshold, y only beyond the small
		// one, so both axes move. Then edge-of-screen and off-screen points.
		send_point(1, 130, 208);
		send_point(2, 0, 0);
		send_point(3, 4095, 65535);
		send_point(4, 600, 1024);
		end_frame(4);
		// An off-screen point still marks slot 10 as seen; slots 1 to 4 went
		// idle and are released.
		send_point(10, 300, 1025);
		end_frame(1);
		// Of the points before a zero-count frame end, the first is reported and
		// the second is not, its flipped y wrapping below zero; every slot is then released.
		send_point(5, 200, 300);
		send_point(6, 4095, 0);
		end_frame(0);
		// After the release-all, slot 1 starts over with a first touch.
		send_point(1, 100, 200);
		end_frame(8);
		// An empty frame releases slot 1 again.
		end_frame(3);
		drain();

		// Random phases, the first two at the extremes of every register.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00);
					quota = 80;
				end
				1: begin
					apply_settings(0, 0, 0, 8'hFF, 8'hFF);
					quota = 30;
				end
				default: begin
					apply_settings(
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
							: $urandom_range(300, 4000),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
							: $urandom_range(300, 4000),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
							: $urandom_range(300, 4000),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
							: $urandom_range(0, 8),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
							: $urandom_range(0, 8));
					quota = 60;
				end
			endcase
			goal = items_sent + quota;
			while (items_sent < goal)
				play_frame();
			drain();
		end

		$display("Run covered %0d input beats under %0d register settings,", beats_in,
			settings_run);
		$display("checking %0d position reports, %0d slot releases and %0d frame syncs.",
			reports, releases, syncs);
		if (mismatches == 0 && awaiting == 0)
			$display("** touch_slot_jitter_filter: PASSED **");
		else
			$display("** touch_slot_jitter_filter: FAILED **");
		$finish;
	end

endmodule
